[design/pcx_rle_line_decoder_defines.svh]
// Assertion macros used by the PCX run-length decoder sequencer.
`ifndef PCX_RLE_LINE_DECODER_DEFINES_SVH
`define PCX_RLE_LINE_DECODER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PCXRLE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PCXRLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pcxrle_pkg.sv]
// Shared types and constants of the PCX run-length decoder.
`default_nettype none

package pcxrle_pkg;

    localparam int BYTE_BITS     = 8;
    localparam int RUN_BITS      = 6;
    localparam int COL_BITS      = 15;
    localparam int LINE_BITS     = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // A byte at or above this mark is a repeat count.
    localparam logic [BYTE_BITS-1:0] COUNT_MARK = 8'hC0;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_BYTES    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VISIBLE_WIDTH = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_COUNT    = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_FLUSH = 3'b100
    } seq_state_t;

    // Commands to the position unit.
    typedef struct packed {
        logic clear;
        logic step;
    } place_ctrl_t;

    // Status of the position unit for the current position.
    typedef struct packed {
        logic visible;
        logic image_end;
        logic fin;
        logic done;
    } place_stat_t;

endpackage

`default_nettype wire

[design/pcxrle_place.sv]
// Position unit: column and line counters that place one decoded byte per step.
`default_nettype none

module pcxrle_place (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic [pcxrle_pkg::COL_BITS-1:0]    line_bytes,
    input  wire logic [pcxrle_pkg::COL_BITS-1:0]    visible_width,
    input  wire logic [pcxrle_pkg::LINE_BITS-1:0]   line_count,
    input  wire pcxrle_pkg::place_ctrl_t            ctrl,
    output pcxrle_pkg::place_stat_t                 stat
);
    import pcxrle_pkg::*;

    logic [COL_BITS-1:0]  col_reg;
    logic [COL_BITS-1:0]  col_next;
    logic [LINE_BITS-1:0] line_reg;
    logic [LINE_BITS-1:0] line_next;
    logic                 done_reg;
    logic                 done_next;

    logic [COL_BITS-1:0]  lb_eff;
    logic [COL_BITS-1:0]  vw_eff;
    logic [LINE_BITS-1:0] lc_eff;
    logic [COL_BITS-1:0]  last_vis;
    logic                 last_line;
    logic                 line_end;
    logic                 visible;

    // A register written as zero behaves as one.
    assign lb_eff = (line_bytes == '0) ? COL_BITS'(1) : line_bytes;
    assign vw_eff = (visible_width == '0) ? COL_BITS'(1) : visible_width;
    assign lc_eff = (line_count == '0) ? LINE_BITS'(1) : line_count;

    // Last visible column is the smaller of the two widths, less one.
    assign last_vis  = ((vw_eff < lb_eff) ? vw_eff : lb_eff) - COL_BITS'(1);
    assign last_line = ({1'b0, line_reg} + (LINE_BITS+1)'(1)) >= {1'b0, lc_eff};
    assign line_end  = ({1'b0, col_reg} + (COL_BITS+1)'(1)) >= {1'b0, lb_eff};
    assign visible   = col_reg < vw_eff;

    assign stat.visible   = visible;
    assign stat.image_end = visible && last_line && (col_reg == last_vis);
    assign stat.fin       = line_end && last_line;
    assign stat.done      = done_reg;

    // Clear the position, or advance one position, wrapping the column at the line length.
    always_comb begin
        col_next  = col_reg;
        line_next = line_reg;
        done_next = done_reg;
        if (ctrl.clear) begin
            col_next  = '0;
            line_next = '0;
            done_next = 1'b0;
        end else if (ctrl.step) begin
            if (line_end) begin
                col_next = '0;
                if (last_line) begin
                    done_next = 1'b1;
                    line_next = '0;
                end else begin
                    line_next = line_reg + LINE_BITS'(1);
                end
            end else begin
                col_next = col_reg + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            line_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            col_reg  <= col_next;
            line_reg <= line_next;
            done_reg <= done_next;
        end
    end

endmodule

`default_nettype wire

[design/pcxrle_ctrl.sv]
// Sequencer: run state, repeat counter, held result and output register.
`default_nettype none
`include "pcx_rle_line_decoder_defines.svh"

module pcxrle_ctrl (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [pcxrle_pkg::BYTE_BITS-1:0]   s_tdata,
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [pcxrle_pkg::BYTE_BITS-1:0]        m_tdata,
    output logic                                    m_tlast,
    output logic                                    m_tuser,
    output pcxrle_pkg::place_ctrl_t                 place_ctrl,
    input  wire pcxrle_pkg::place_stat_t            place_stat
);
    import pcxrle_pkg::*;

    seq_state_t            state_reg, state_next;
    logic                  awaiting_reg, awaiting_next;
    logic [RUN_BITS-1:0]   run_len_reg, run_len_next;
    logic [RUN_BITS-1:0]   rep_cnt_reg, rep_cnt_next;
    logic [BYTE_BITS-1:0]  value_reg, value_next;

    logic                  pend_vld_reg, pend_vld_next;
    logic [BYTE_BITS-1:0]  pend_pix_reg, pend_pix_next;
    logic                  pend_end_reg, pend_end_next;

    logic                  out_vld_reg, out_vld_next;
    logic [BYTE_BITS-1:0]  out_pix_reg, out_pix_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_end_reg, out_end_next;

    logic                  accept;
    logic                  out_free;
    logic                  awaiting_eff;
    logic [RUN_BITS-1:0]   run_len_eff;
    logic                  done_eff;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;

    // A frame start clears run state before the byte is looked at.
    assign awaiting_eff = s_tuser ? 1'b0 : awaiting_reg;
    assign run_len_eff  = s_tuser ? '0 : run_len_reg;
    assign done_eff     = s_tuser ? 1'b0 : place_stat.done;

    assign place_ctrl.clear = accept && s_tuser;
    assign place_ctrl.step  = (state_reg == ST_RUN) && out_free;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_end_reg;

    // Sequencer: decode a request, then step the position unit once per pixel.
    always_comb begin
        state_next    = state_reg;
        awaiting_next = awaiting_reg;
        run_len_next  = run_len_reg;
        rep_cnt_next  = rep_cnt_reg;
        value_next    = value_reg;
        pend_vld_next = pend_vld_reg;
        pend_pix_next = pend_pix_reg;
        pend_end_next = pend_end_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        out_pix_next  = out_pix_reg;
        out_last_next = out_last_reg;
        out_end_next  = out_end_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    awaiting_next = awaiting_eff;
                    run_len_next  = run_len_eff;
                    if (done_eff) begin
                        // Image complete: the byte is dropped.
                    end else if (awaiting_eff) begin
                        awaiting_next = 1'b0;
                        run_len_next  = '0;
                        value_next    = s_tdata;
                        rep_cnt_next  = run_len_eff;
                        if (run_len_eff != '0) begin
                            state_next = ST_RUN;
                        end
                    end else if (s_tdata >= COUNT_MARK) begin
                        awaiting_next = 1'b1;
                        run_len_next  = s_tdata[RUN_BITS-1:0];
                    end else begin
                        value_next   = s_tdata;
                        rep_cnt_next = RUN_BITS'(1);
                        state_next   = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    // A new visible pixel pushes the held one out as not last.
                    if (place_stat.visible) begin
                        if (pend_vld_reg) begin
                            out_vld_next  = 1'b1;
                            out_pix_next  = pend_pix_reg;
                            out_last_next = 1'b0;
                            out_end_next  = pend_end_reg;
                        end
                        pend_vld_next = 1'b1;
                        pend_pix_next = value_reg;
                        pend_end_next = place_stat.image_end;
                    end
                    rep_cnt_next = rep_cnt_reg - RUN_BITS'(1);
                    if (rep_cnt_reg == RUN_BITS'(1) || place_stat.fin) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                // The held pixel is the last result of this request.
                if (!pend_vld_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_vld_next  = 1'b1;
                    out_pix_next  = pend_pix_reg;
                    out_last_next = 1'b1;
                    out_end_next  = pend_end_reg;
                    pend_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            awaiting_reg <= 1'b0;
            run_len_reg  <= '0;
            rep_cnt_reg  <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            awaiting_reg <= awaiting_next;
            run_len_reg  <= run_len_next;
            rep_cnt_reg  <= rep_cnt_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        value_reg    <= value_next;
        pend_pix_reg <= pend_pix_next;
        pend_end_reg <= pend_end_next;
        out_pix_reg  <= out_pix_next;
        out_last_reg <= out_last_next;
        out_end_reg  <= out_end_next;
    end

    `PCXRLE_ASSERT_SAME(a_run_cnt_live, state_reg == ST_RUN, rep_cnt_reg != '0, "run with zero count")
    `PCXRLE_ASSERT_SAME(a_idle_no_pend, state_reg == ST_IDLE, !pend_vld_reg, "held pixel in idle")
    `PCXRLE_ASSERT_NEXT(a_idle_no_push, state_reg == ST_IDLE && !out_vld_reg, !out_vld_reg, "push from idle")
    `PCXRLE_ASSERT_SAME(a_end_is_last, out_vld_reg && out_end_reg, out_last_reg, "image end not last")

endmodule

`default_nettype wire

[design/pcx_rle_line_decoder.sv]
// Top level of the PCX run-length decoder: configuration registers and unit wiring.
`default_nettype none

// Decodes a PCX run-length byte stream, one encoded byte per request, into the
// visible pixel bytes of each scan line; line padding and anything past the last
// line are dropped, and s_tuser restarts a frame. A count byte is only stored.
// Literal bytes and runs are placed by a single position unit, one decoded byte
// per cycle while the output is not stalled, and each result is held one step
// so that its last flag can be set; input is not taken while a byte is being
// placed. A stalled output holds the position unit. Configuration writes are
// taken at any time but belong between frames.
module pcx_rle_line_decoder (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // tdata: encoded_byte[7:0]
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [pcxrle_pkg::BYTE_BITS-1:0]     s_tdata,
    // tuser: frame_start[0]
    input  wire logic                                 s_tuser,
    // tdata: pixel[7:0]
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [pcxrle_pkg::BYTE_BITS-1:0]          m_tdata,
    output logic                                      m_tlast,
    // tuser: image_end[0]
    output logic                                      m_tuser,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [pcxrle_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [pcxrle_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import pcxrle_pkg::*;

    logic [COL_BITS-1:0]  line_bytes_reg;
    logic [COL_BITS-1:0]  visible_width_reg;
    logic [LINE_BITS-1:0] line_count_reg;

    place_ctrl_t          place_ctrl;
    place_stat_t          place_stat;

    assign cfg_ready = 1'b1;

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_bytes_reg    <= COL_BITS'(1);
            visible_width_reg <= COL_BITS'(1);
            line_count_reg    <= LINE_BITS'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_LINE_BYTES:    line_bytes_reg    <= cfg_data[COL_BITS-1:0];
                CFG_VISIBLE_WIDTH: visible_width_reg <= cfg_data[COL_BITS-1:0];
                CFG_LINE_COUNT:    line_count_reg    <= cfg_data[LINE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    pcxrle_place u_place (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .line_bytes    (line_bytes_reg),
        .visible_width (visible_width_reg),
        .line_count    (line_count_reg),
        .ctrl          (place_ctrl),
        .stat          (place_stat)
    );

    pcxrle_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .place_ctrl (place_ctrl),
        .place_stat (place_stat)
    );

endmodule

`default_nettype wire
